// ===== sv/fdm_pkg.sv =====
`default_nettype none
package fdm_pkg;

  localparam int unsigned COORD_W       = 13;
  localparam int unsigned MAX_DIM       = 4096;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 24;
  localparam int unsigned APP_W         = 24;
  localparam int unsigned CORDIC_STAGES = 16;

  localparam int unsigned DIFF_W     = 14;
  localparam int unsigned SQ_W       = 25;
  localparam int unsigned R2_W       = 26;
  localparam int unsigned RAD_N_W    = 43;
  localparam int unsigned SQRT_STEPS = 21;
  localparam int unsigned R8_W       = 21;
  localparam int unsigned YAW_W      = 45;
  localparam int unsigned MOD_STEPS  = 4;
  localparam int unsigned YAW_LO_W   = 15;
  localparam int unsigned YAW_HI_W   = YAW_W - YAW_LO_W;
  localparam int unsigned RCP_W      = 32;
  localparam int unsigned RCP_SHIFT  = 61;
  localparam int unsigned RCP_PROD_W = YAW_HI_W + RCP_W;
  localparam int unsigned QEST_W     = 15;
  localparam int unsigned QT_W       = 46;
  localparam int unsigned REM_W      = 32;
  localparam int unsigned RED_W      = 31;
  localparam int unsigned ANG_W      = 34;
  localparam int unsigned PROD_W     = 48;
  localparam int unsigned NUM_W      = 52;
  localparam int unsigned QUO_W      = 31;
  localparam int unsigned DIV_STEPS  = 31;
  localparam int unsigned ATAN_LEN   = 24;
  localparam int unsigned OUT_W      = 16;

  localparam logic [30:0]        TWO_PI_U    = 31'd1686629713;
  localparam logic signed [32:0] TWO_PI_Q28  = 33'sd1686629713;
  localparam logic signed [32:0] PI_Q28      = 33'sd843314857;
  localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;
  localparam logic signed [ANG_W-1:0] GAIN_Q30 = 34'sd652032874;

  // reciprocal of TWO_PI_U (two pi in q28), scaled by 2^RCP_SHIFT
  localparam logic [RCP_W-1:0] TWO_PI_RCP =
    RCP_W'((64'd1 << RCP_SHIFT) / {33'd0, TWO_PI_U});

  localparam logic [COORD_W-1:0] VIEW_WIDTH_RST  = 13'd640;
  localparam logic [COORD_W-1:0] VIEW_HEIGHT_RST = 13'd480;
  localparam logic [APP_W-1:0]   APP_RST         = 24'd2574;

  localparam logic signed [OUT_W-1:0] Q15_MAX = 16'sh7fff;
  localparam logic signed [OUT_W-1:0] Q15_MIN = 16'sh8000;

  localparam logic [29:0] ATAN_Q30 [ATAN_LEN] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_WIDTH      = 2'd0,
    REG_VIEW_HEIGHT     = 2'd1,
    REG_ANGLE_PER_PIXEL = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] dir_x;
    logic signed [OUT_W-1:0] dir_y;
    logic signed [OUT_W-1:0] dir_z;
  } out_word_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     zero;
    logic [R8_W-1:0]          r8;
  } side_t;

  typedef struct packed {
    logic [RAD_N_W-1:0] n;
    logic [RAD_N_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    negc;
  } cord_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] cosv;
    logic [NUM_W-1:0]        nx;
    logic [NUM_W-1:0]        ny;
    logic [QUO_W-1:0]        qx;
    logic [QUO_W-1:0]        qy;
    logic                    sx;
    logic                    sy;
  } div_t;

  function automatic logic [COORD_W-1:0] clamp_dim(logic [COORD_W-1:0] v);
    return (v > COORD_W'(MAX_DIM)) ? COORD_W'(MAX_DIM) : v;
  endfunction

  function automatic logic signed [OUT_W-1:0] to_q15(logic signed [ANG_W-1:0] v);
    logic signed [ANG_W:0] s;
    s = {v[ANG_W-1], v} + (ANG_W+1)'(16384);
    s = s >>> 15;
    if (s > (ANG_W+1)'(Q15_MAX)) begin
      return Q15_MAX;
    end else if (s < (ANG_W+1)'(Q15_MIN)) begin
      return Q15_MIN;
    end
    return s[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/fisheye_direction_map_unit.sv =====
// channel | dir | handshake                 | word
// --------+-----+---------------------------+-----------------------------------
// in      | in  | in_valid_i / in_ready_o   | in_word_i  (point_x, point_y)
// out     | out | out_valid_o / out_ready_i | out_word_o (dir_x, dir_y, dir_z)
// cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one word per cycle while the output is not stalled; the pipeline holds the
// radius square root (21 steps), angle reduction (4), cordic and
// the two divide lanes (31 steps each, in parallel), one step per register stage
// reset clears stage valid bits and loads the register defaults
// a stalled output freezes only full stages; empty stages keep filling

`default_nettype none
module fisheye_direction_map_unit #(
  parameter int unsigned CORDIC_STAGES = fdm_pkg::CORDIC_STAGES
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  fdm_pkg::in_word_t                  in_word_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output fdm_pkg::out_word_t                 out_word_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [fdm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [fdm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned ST_SUB   = 0;
  localparam int unsigned ST_SQ    = 1;
  localparam int unsigned ST_SUM   = 2;
  localparam int unsigned ST_MUL   = ST_SUM + fdm_pkg::SQRT_STEPS + 1;
  localparam int unsigned ST_FOLD  = ST_MUL + fdm_pkg::MOD_STEPS + 1;
  localparam int unsigned ST_POST  = ST_FOLD + CORDIC_STAGES + 1;
  localparam int unsigned ST_ABS   = ST_POST + 1;
  localparam int unsigned ST_OUT   = ST_ABS + fdm_pkg::DIV_STEPS + 1;
  localparam int unsigned NST      = ST_OUT + 1;

  // configuration
  logic [fdm_pkg::COORD_W-1:0] view_width_q, view_height_q;
  logic [fdm_pkg::APP_W-1:0]   app_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_width_q  <= fdm_pkg::VIEW_WIDTH_RST;
      view_height_q <= fdm_pkg::VIEW_HEIGHT_RST;
      app_q         <= fdm_pkg::APP_RST;
    end else if (cfg_valid_i) begin
      unique case (fdm_pkg::cfg_reg_e'(cfg_index_i))
        fdm_pkg::REG_VIEW_WIDTH: begin
          view_width_q <= cfg_data_i[fdm_pkg::COORD_W-1:0];
        end
        fdm_pkg::REG_VIEW_HEIGHT: begin
          view_height_q <= cfg_data_i[fdm_pkg::COORD_W-1:0];
        end
        fdm_pkg::REG_ANGLE_PER_PIXEL: begin
          app_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // stage valid bits
  logic [NST-1:0] v_q, v_d, ld;
  logic           en;

  always_comb begin
    en = out_ready_i | ~v_q[ST_OUT];
    for (int k = 0; k < NST; k++) begin
      ld[k] = en | ~v_q[k];
    end
    for (int k = 0; k < NST - 1; k++) begin
      if (ld[k]) begin
        v_d[k] = (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
      end else if (ld[k+1]) begin
        v_d[k] = 1'b0;
      end else begin
        v_d[k] = v_q[k];
      end
    end
    v_d[ST_OUT] = ld[ST_OUT] ? v_q[ST_OUT-1] : v_q[ST_OUT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = ld[0];
  assign out_valid_o = v_q[ST_OUT];

  // side data carried through to the divide lanes
  fdm_pkg::side_t side_q [ST_OUT];
  fdm_pkg::side_t side_d [ST_OUT];

  logic [fdm_pkg::SQ_W-1:0] sqx_q, sqy_q;
  fdm_pkg::sqrt_t           rt_q  [fdm_pkg::SQRT_STEPS+1];
  logic [fdm_pkg::YAW_W-1:0]      yaw_q;
  logic [fdm_pkg::RCP_PROD_W-1:0] rcp_q;
  logic [fdm_pkg::REM_W-1:0]      ylo1_q, ylo2_q, qt_q, rm_q;
  logic [fdm_pkg::RED_W-1:0]      red_q;
  fdm_pkg::cord_t           cor_q [CORDIC_STAGES+1];
  logic signed [fdm_pkg::ANG_W-1:0]  cos_q;
  logic signed [fdm_pkg::PROD_W-1:0] px_q, py_q;
  fdm_pkg::div_t            dv_q  [fdm_pkg::DIV_STEPS+1];
  fdm_pkg::out_word_t       out_q;

  // centre offset
  always_comb begin
    logic [fdm_pkg::COORD_W-1:0] cx, cy;
    cx = fdm_pkg::clamp_dim(view_width_q) >> 1;
    cy = fdm_pkg::clamp_dim(view_height_q) >> 1;
    side_d[ST_SUB]      = '0;
    side_d[ST_SUB].dx   = fdm_pkg::DIFF_W'(fdm_pkg::clamp_dim(in_word_i.point_x))
                          - fdm_pkg::DIFF_W'(cx);
    side_d[ST_SUB].dy   = fdm_pkg::DIFF_W'(fdm_pkg::clamp_dim(in_word_i.point_y))
                          - fdm_pkg::DIFF_W'(cy);
  end

  for (genvar k = 1; k < ST_OUT; k++) begin : g_side
    always_comb begin
      side_d[k] = side_q[k-1];
      if (k == ST_SUM) begin
        side_d[k].zero = ({1'b0, sqx_q} + {1'b0, sqy_q}) == '0;
      end
      if (k == ST_MUL) begin
        side_d[k].r8 = rt_q[fdm_pkg::SQRT_STEPS].root[fdm_pkg::R8_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < ST_OUT; k++) begin : g_side_reg
    always_ff @(posedge clk_i) begin
      if (ld[k]) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  // squares
  always_ff @(posedge clk_i) begin
    logic signed [2*fdm_pkg::DIFF_W-1:0] mx, my;
    mx = side_q[ST_SUB].dx * side_q[ST_SUB].dx;
    my = side_q[ST_SUB].dy * side_q[ST_SUB].dy;
    if (ld[ST_SQ]) begin
      sqx_q <= mx[fdm_pkg::SQ_W-1:0];
      sqy_q <= my[fdm_pkg::SQ_W-1:0];
    end
  end

  // radius in q.8 by digit-by-digit square root
  always_ff @(posedge clk_i) begin
    logic [fdm_pkg::R2_W-1:0] r2;
    r2 = {1'b0, sqx_q} + {1'b0, sqy_q};
    if (ld[ST_SUM]) begin
      rt_q[0].n    <= fdm_pkg::RAD_N_W'(r2) << 16;
      rt_q[0].root <= '0;
    end
  end

  for (genvar j = 1; j <= fdm_pkg::SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [fdm_pkg::RAD_N_W-1:0] BIT =
      fdm_pkg::RAD_N_W'(1) << (2 * (fdm_pkg::SQRT_STEPS - j));
    always_ff @(posedge clk_i) begin
      logic [fdm_pkg::RAD_N_W-1:0] trial;
      trial = rt_q[j-1].root + BIT;
      if (ld[ST_SUM+j]) begin
        if (rt_q[j-1].n >= trial) begin
          rt_q[j].n    <= rt_q[j-1].n - trial;
          rt_q[j].root <= (rt_q[j-1].root >> 1) + BIT;
        end else begin
          rt_q[j].n    <= rt_q[j-1].n;
          rt_q[j].root <= rt_q[j-1].root >> 1;
        end
      end
    end
  end

  // off-axis angle, then reduce modulo 2 pi by a reciprocal multiply
  // and one correcting subtract
  always_ff @(posedge clk_i) begin
    if (ld[ST_MUL]) begin
      yaw_q <= fdm_pkg::YAW_W'(rt_q[fdm_pkg::SQRT_STEPS].root[fdm_pkg::R8_W-1:0])
               * fdm_pkg::YAW_W'(app_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_MUL+1]) begin
      rcp_q  <= fdm_pkg::RCP_PROD_W'(yaw_q[fdm_pkg::YAW_W-1 -: fdm_pkg::YAW_HI_W])
                * fdm_pkg::RCP_PROD_W'(fdm_pkg::TWO_PI_RCP);
      ylo1_q <= yaw_q[fdm_pkg::REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [fdm_pkg::QT_W-1:0] qt;
    qt = fdm_pkg::QT_W'(rcp_q[fdm_pkg::RCP_SHIFT-fdm_pkg::YAW_LO_W +: fdm_pkg::QEST_W])
         * fdm_pkg::QT_W'(fdm_pkg::TWO_PI_U);
    if (ld[ST_MUL+2]) begin
      qt_q   <= qt[fdm_pkg::REM_W-1:0];
      ylo2_q <= ylo1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_MUL+3]) begin
      rm_q <= ylo2_q - qt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_MUL+4]) begin
      if (rm_q >= fdm_pkg::REM_W'(fdm_pkg::TWO_PI_U)) begin
        red_q <= fdm_pkg::RED_W'(rm_q - fdm_pkg::REM_W'(fdm_pkg::TWO_PI_U));
      end else begin
        red_q <= rm_q[fdm_pkg::RED_W-1:0];
      end
    end
  end

  // fold into the right half plane
  always_ff @(posedge clk_i) begin
    logic signed [32:0] a;
    logic               negc;
    a    = signed'({2'b00, red_q});
    negc = 1'b0;
    if (a > fdm_pkg::PI_Q28) begin
      a = a - fdm_pkg::TWO_PI_Q28;
    end
    if (a > fdm_pkg::HALF_PI_Q28) begin
      a    = fdm_pkg::PI_Q28 - a;
      negc = 1'b1;
    end else if (a < -fdm_pkg::HALF_PI_Q28) begin
      a    = -fdm_pkg::PI_Q28 - a;
      negc = 1'b1;
    end
    if (ld[ST_FOLD]) begin
      cor_q[0].x    <= fdm_pkg::GAIN_Q30;
      cor_q[0].y    <= '0;
      cor_q[0].z    <= fdm_pkg::ANG_W'(a) <<< 2;
      cor_q[0].negc <= negc;
    end
  end

  // rotation cordic, one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    localparam logic signed [fdm_pkg::ANG_W-1:0] ATAN =
      fdm_pkg::ANG_W'(fdm_pkg::ATAN_Q30[i]);
    always_ff @(posedge clk_i) begin
      logic signed [fdm_pkg::ANG_W-1:0] x, y, z;
      x = cor_q[i].x;
      y = cor_q[i].y;
      z = cor_q[i].z;
      if (ld[ST_FOLD+i+1]) begin
        if (z >= 0) begin
          cor_q[i+1].x <= x - (y >>> i);
          cor_q[i+1].y <= y + (x >>> i);
          cor_q[i+1].z <= z - ATAN;
        end else begin
          cor_q[i+1].x <= x + (y >>> i);
          cor_q[i+1].y <= y - (x >>> i);
          cor_q[i+1].z <= z + ATAN;
        end
        cor_q[i+1].negc <= cor_q[i].negc;
      end
    end
  end

  // sine times offset, and the cosine with its fold sign restored
  always_ff @(posedge clk_i) begin
    logic signed [fdm_pkg::ANG_W-1:0]  y;
    logic signed [fdm_pkg::DIFF_W-1:0] dx, dy;
    y  = cor_q[CORDIC_STAGES].y;
    dx = side_q[ST_POST-1].dx;
    dy = side_q[ST_POST-1].dy;
    if (ld[ST_POST]) begin
      cos_q <= cor_q[CORDIC_STAGES].negc ? -cor_q[CORDIC_STAGES].x
                                         : cor_q[CORDIC_STAGES].x;
      px_q  <= y * dx;
      py_q  <= y * dy;
    end
  end

  // sign and magnitude for the divide lanes
  always_ff @(posedge clk_i) begin
    logic [fdm_pkg::PROD_W-1:0] ax, ay;
    ax = px_q[fdm_pkg::PROD_W-1] ? -px_q : px_q;
    ay = py_q[fdm_pkg::PROD_W-1] ? -py_q : py_q;
    if (ld[ST_ABS]) begin
      dv_q[0].cosv <= cos_q;
      dv_q[0].nx   <= fdm_pkg::NUM_W'(ax) << 8;
      dv_q[0].ny   <= fdm_pkg::NUM_W'(ay) << 8;
      dv_q[0].qx   <= '0;
      dv_q[0].qy   <= '0;
      dv_q[0].sx   <= px_q[fdm_pkg::PROD_W-1];
      dv_q[0].sy   <= py_q[fdm_pkg::PROD_W-1];
    end
  end

  // restoring division by the radius, one quotient bit per stage
  for (genvar j = 1; j <= fdm_pkg::DIV_STEPS; j++) begin : g_div
    localparam int unsigned K = fdm_pkg::DIV_STEPS - j;
    always_ff @(posedge clk_i) begin
      logic [fdm_pkg::NUM_W-1:0] dsh;
      fdm_pkg::div_t             nxt;
      dsh = fdm_pkg::NUM_W'(side_q[ST_ABS+j-1].r8) << K;
      nxt = dv_q[j-1];
      if (dv_q[j-1].nx >= dsh) begin
        nxt.nx    = dv_q[j-1].nx - dsh;
        nxt.qx[K] = 1'b1;
      end
      if (dv_q[j-1].ny >= dsh) begin
        nxt.ny    = dv_q[j-1].ny - dsh;
        nxt.qy[K] = 1'b1;
      end
      if (ld[ST_ABS+j]) begin
        dv_q[j] <= nxt;
      end
    end
  end

  // rounding, saturation and the centre point
  always_ff @(posedge clk_i) begin
    logic signed [fdm_pkg::ANG_W-1:0] qx, qy;
    qx = fdm_pkg::ANG_W'(dv_q[fdm_pkg::DIV_STEPS].qx);
    qy = fdm_pkg::ANG_W'(dv_q[fdm_pkg::DIV_STEPS].qy);
    if (dv_q[fdm_pkg::DIV_STEPS].sx) begin
      qx = -qx;
    end
    if (dv_q[fdm_pkg::DIV_STEPS].sy) begin
      qy = -qy;
    end
    if (ld[ST_OUT]) begin
      if (side_q[ST_OUT-1].zero) begin
        out_q.dir_x <= '0;
        out_q.dir_y <= '0;
        out_q.dir_z <= fdm_pkg::Q15_MAX;
      end else begin
        out_q.dir_x <= fdm_pkg::to_q15(qx);
        out_q.dir_y <= fdm_pkg::to_q15(qy);
        out_q.dir_z <= fdm_pkg::to_q15(dv_q[fdm_pkg::DIV_STEPS].cosv);
      end
    end
  end

  assign out_word_o = out_q;

`ifndef ASSERT_OFF
  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted word did not reach the first stage");

  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_FOLD-1] |-> (red_q < fdm_pkg::TWO_PI_U))
    else $error("angle not reduced below two pi");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_FOLD] |-> (cor_q[0].z <= fdm_pkg::ANG_W'(fdm_pkg::HALF_PI_Q28) <<< 2) &&
                     (cor_q[0].z >= -(fdm_pkg::ANG_W'(fdm_pkg::HALF_PI_Q28) <<< 2)))
    else $error("folded angle outside half plane");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_OUT-1] && !side_q[ST_OUT-1].zero |->
      (dv_q[fdm_pkg::DIV_STEPS].nx < fdm_pkg::NUM_W'(side_q[ST_OUT-1].r8)) &&
      (dv_q[fdm_pkg::DIV_STEPS].ny < fdm_pkg::NUM_W'(side_q[ST_OUT-1].r8)))
    else $error("quotient overflow in divide lane");
`endif

endmodule
`default_nettype wire
